/* rtl/core/gtlo_pkg.sv */
// ----------------------------------------------------------------------------
// gtlo_pkg
// Shared types, constants and the arctangent table of the offset pipeline.
// ----------------------------------------------------------------------------
package gtlo_pkg;

    localparam int CW = 40;
    typedef logic signed [CW-1:0] t_cw;

    localparam logic [1:0] CFG_ORIGIN_LAT  = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_LONG = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_ALT  = 2'd2;

    localparam logic [63:0] ONE_Q32         = 64'd4294967296;
    localparam logic [63:0] GAIN_Q32        = 64'd2608131496;
    localparam logic [63:0] RAD_Q64         = 64'd32195642036;
    localparam logic [63:0] HALF_RAD_Q64    = 64'd16097821018;
    localparam logic [63:0] MM_PER_UNIT_Q32 = 64'd47757857342;
    localparam logic [63:0] TWO_R_MM        = 64'd12742000000;
    localparam logic [63:0] HALF_TURN       = 64'd1800000000;
    localparam logic [63:0] QUARTER_TURN    = 64'd900000000;
    localparam logic [63:0] FULL_TURN       = 64'd3600000000;
    localparam logic [63:0] ROUND_HALF      = 64'd2147483648;

    localparam logic [31:0] ATAN_TAB [33] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635, 32'd268086748,
        32'd134174063, 32'd67103403, 32'd33553749, 32'd16777131, 32'd8388597,
        32'd4194303, 32'd2097152, 32'd1048576, 32'd524288, 32'd262144, 32'd131072,
        32'd65536, 32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024,
        32'd512, 32'd256, 32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1
    };

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } t_sq;

    typedef struct packed {
        logic [32:0] p;
        logic        pz;
    } t_sq_side;

    typedef struct packed {
        logic [34:0]        ns;
        logic signed [27:0] down;
    } t_side;

    function automatic t_cw atan_q32(input int i);
        logic [5:0] k;
        k = 6'(i);
        if (i >= 0 && i <= 32) begin
            return t_cw'({8'd0, ATAN_TAB[k]});
        end
        return '0;
    endfunction

endpackage

/* rtl/core/gtlo_if.sv */
// ----------------------------------------------------------------------------
// gtlo_if
// Valid/ready channels for position beats and offset beats.
// ----------------------------------------------------------------------------
interface gtlo_in_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] current_latitude;
    logic signed [31:0] current_longitude;
    logic signed [27:0] current_altitude;

    modport source (output valid, current_latitude, current_longitude, current_altitude,
                    input ready);
    modport sink (input valid, current_latitude, current_longitude, current_altitude,
                  output ready);
endinterface

interface gtlo_out_if;
    logic               valid;
    logic               ready;
    logic [34:0]        east_west_distance;
    logic [34:0]        north_south_distance;
    logic signed [27:0] down_offset;

    modport source (output valid, east_west_distance, north_south_distance, down_offset,
                    input ready);
    modport sink (input valid, east_west_distance, north_south_distance, down_offset,
                  output ready);
endinterface

/* rtl/core/gtlo_cordic_cell.sv */
// ----------------------------------------------------------------------------
// gtlo_cordic_cell
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module gtlo_cordic_cell import gtlo_pkg::*; #(
    parameter int IDX    = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_cw  i_x,
    input  t_cw  i_y,
    input  t_cw  i_z,
    output t_cw  o_x,
    output t_cw  o_y,
    output t_cw  o_z
);

    localparam t_cw ANG = atan_q32(IDX);

    t_cw r_x, r_y, r_z;
    t_cw xs, ys;
    logic u;

    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;
    assign u  = VECTOR ? i_y[CW-1] : ~i_z[CW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (u) begin
                r_x <= i_x - ys;
                r_y <= i_y + xs;
                r_z <= i_z - ANG;
            end else begin
                r_x <= i_x + ys;
                r_y <= i_y - xs;
                r_z <= i_z + ANG;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

/* rtl/core/gtlo_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// gtlo_sqrt_cell
// One registered step of the restoring integer square root, one result bit.
// ----------------------------------------------------------------------------
module gtlo_sqrt_cell import gtlo_pkg::*; #(
    parameter int K = 0
) (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_sq      i_st,
    input  t_sq_side i_sd,
    output t_sq      o_st,
    output t_sq_side o_sd
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

    t_sq      r_st;
    t_sq_side r_sd;
    logic [63:0] t;

    assign t = i_st.r + BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd <= i_sd;
            if (i_st.n >= t) begin
                r_st.n <= i_st.n - t;
                r_st.r <= (i_st.r >> 1) + BIT;
            end else begin
                r_st.n <= i_st.n;
                r_st.r <= i_st.r >> 1;
            end
        end
    end

    assign o_st = r_st;
    assign o_sd = r_sd;

endmodule

/* rtl/core/geodetic_to_local_offset.sv */
// ----------------------------------------------------------------------------
// geodetic_to_local_offset
// Offset of a position fix from a configured origin: east-west arc along the
// origin latitude, meridian arc and altitude difference.
// ----------------------------------------------------------------------------
// Usage:
//   Write the origin through the register port while the block is idle.
//   Position beats enter on i_pos, offset beats leave on o_ofs, both
//   valid/ready; one offset beat per position beat, in order.
//   The path from acceptance to o_ofs.valid runs through the two chains of
//   CORDIC cells and the 32-cell square root between them. Throughput is
//   one beat per cycle while the pipeline is not held; every stage is a
//   registered cell that hands its data on each cycle the pipeline advances.
//   A skid register behind the output takes one more beat while o_ofs is
//   stalled; after that i_pos.ready drops and the whole pipeline holds.
//   Reset clears the origin to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module geodetic_to_local_offset import gtlo_pkg::*; #(
    parameter int CORDIC_STAGES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    gtlo_in_if.sink           i_pos,
    gtlo_out_if.source        o_ofs
);

    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 2 * N + 43;
    localparam int DLY = LAT - 3;

    typedef struct packed {
        logic [34:0]        ew;
        logic [34:0]        ns;
        logic signed [27:0] down;
    } t_res;

    function automatic logic [32:0] clamp_unit(input t_cw v);
        if (v[CW-1]) begin
            return '0;
        end
        if (v > t_cw'(ONE_Q32)) begin
            return ONE_Q32[32:0];
        end
        return v[32:0];
    endfunction

    logic signed [30:0] r_olat;
    logic signed [31:0] r_olong;
    logic signed [27:0] r_oalt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olat  <= '0;
            r_olong <= '0;
            r_oalt  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_LAT:  r_olat  <= i_cfg_data[30:0];
                CFG_ORIGIN_LONG: r_olong <= i_cfg_data;
                CFG_ORIGIN_ALT:  r_oalt  <= i_cfg_data[27:0];
                default: ;
            endcase
        end
    end

    logic en, acc;
    logic [LAT-1:0] r_v;
    logic r_o_v, r_s_v;
    t_res r_o, r_s, res;

    assign en  = ~r_s_v;
    assign acc = i_pos.valid & en;
    assign i_pos.ready = en;

    // stage A: differences and magnitudes
    logic signed [31:0] d_lat;
    logic signed [32:0] d_long;
    logic signed [28:0] d_alt;
    logic [30:0] r_a_dlat, r_a_m;
    logic [32:0] r_a_dlong;
    logic signed [27:0] r_a_down, n_a_down;

    assign d_lat  = 32'(i_pos.current_latitude) - 32'(r_olat);
    assign d_long = 33'(i_pos.current_longitude) - 33'(r_olong);
    assign d_alt  = 29'(r_oalt) - 29'(i_pos.current_altitude);

    always_comb begin
        if (d_alt[28] != d_alt[27]) begin
            n_a_down = d_alt[28] ? {1'b1, 27'd0} : {1'b0, {27{1'b1}}};
        end else begin
            n_a_down = d_alt[27:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dlat  <= d_lat[31] ? 31'(-d_lat) : 31'(d_lat);
            r_a_dlong <= d_long[32] ? 33'(-d_long) : 33'(d_long);
            r_a_m     <= r_olat[30] ? 31'(-r_olat) : 31'(r_olat);
            r_a_down  <= n_a_down;
        end
    end

    // stage B: fold into half a turn
    logic [32:0] h_mod;
    logic [30:0] r_b_dlat, r_b_h;
    logic [29:0] r_b_m;
    logic signed [27:0] r_b_down;

    assign h_mod = (r_a_dlong >= FULL_TURN[32:0]) ? r_a_dlong - FULL_TURN[32:0] : r_a_dlong;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_dlat <= (r_a_dlat > HALF_TURN[30:0]) ? 31'(FULL_TURN[31:0] - 32'(r_a_dlat))
                                                     : r_a_dlat;
            r_b_h    <= (h_mod > HALF_TURN[32:0]) ? 31'(FULL_TURN[32:0] - h_mod)
                                                  : h_mod[30:0];
            r_b_m    <= (r_a_m > QUARTER_TURN[30:0]) ? 30'(HALF_TURN[30:0] - r_a_m)
                                                     : r_a_m[29:0];
            r_b_down <= r_a_down;
        end
    end

    // stage C: partial products
    logic [62:0] r_c_ns_lo, r_c_zh_lo, r_c_zm_lo;
    logic [34:0] r_c_ns_hi;
    logic [32:0] r_c_zh_hi, r_c_zm_hi;
    logic signed [27:0] r_c_down;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ns_lo <= 63'(r_b_dlat) * 63'(MM_PER_UNIT_Q32[31:0]);
            r_c_ns_hi <= 35'(r_b_dlat) * 35'(MM_PER_UNIT_Q32[35:32]);
            r_c_zh_lo <= 63'(r_b_h) * 63'(HALF_RAD_Q64[31:0]);
            r_c_zh_hi <= 33'(r_b_h) * 33'(HALF_RAD_Q64[33:32]);
            r_c_zm_lo <= 63'(r_b_m) * 63'(RAD_Q64[31:0]);
            r_c_zm_hi <= 33'(r_b_m) * 33'(RAD_Q64[34:32]);
            r_c_down  <= r_b_down;
        end
    end

    // stage D: rounded sums
    logic [35:0] ns_sum;
    logic [33:0] zh_sum, zm_sum;
    logic [32:0] r_d_zh, r_d_zm;
    t_side r_dl [DLY];

    assign ns_sum = 36'(r_c_ns_hi) + 36'((r_c_ns_lo + 63'(ROUND_HALF)) >> 32);
    assign zh_sum = 34'(r_c_zh_hi) + 34'((r_c_zh_lo + 63'(ROUND_HALF)) >> 32);
    assign zm_sum = 34'(r_c_zm_hi) + 34'((r_c_zm_lo + 63'(ROUND_HALF)) >> 32);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_zh <= zh_sum[32:0];
            r_d_zm <= zm_sum[32:0];
            r_dl[0].ns   <= ns_sum[34:0];
            r_dl[0].down <= r_c_down;
            for (int j = 1; j < DLY; j++) begin
                r_dl[j] <= r_dl[j-1];
            end
        end
    end

    // rotation chains: sine of half longitude, cosine of origin latitude
    t_cw rh_x [N+1];
    t_cw rh_y [N+1];
    t_cw rh_z [N+1];
    t_cw rm_x [N+1];
    t_cw rm_y [N+1];
    t_cw rm_z [N+1];

    assign rh_x[0] = t_cw'(GAIN_Q32);
    assign rh_y[0] = '0;
    assign rh_z[0] = t_cw'({7'd0, r_d_zh});
    assign rm_x[0] = t_cw'(GAIN_Q32);
    assign rm_y[0] = '0;
    assign rm_z[0] = t_cw'({7'd0, r_d_zm});

    for (genvar g = 0; g < N; g++) begin : g_rot
        gtlo_cordic_cell #(.IDX(g), .VECTOR(1'b0)) u_h (
            .i_clk(i_clk), .i_en(en),
            .i_x(rh_x[g]), .i_y(rh_y[g]), .i_z(rh_z[g]),
            .o_x(rh_x[g+1]), .o_y(rh_y[g+1]), .o_z(rh_z[g+1])
        );
        gtlo_cordic_cell #(.IDX(g), .VECTOR(1'b0)) u_m (
            .i_clk(i_clk), .i_en(en),
            .i_x(rm_x[g]), .i_y(rm_y[g]), .i_z(rm_z[g]),
            .o_x(rm_x[g+1]), .o_y(rm_y[g+1]), .o_z(rm_z[g+1])
        );
    end

    // stages E to I: product, its complement square
    logic [32:0] r_e_s, r_e_c, r_f_s, r_f_c, r_g_p, r_h_p;
    logic [63:0] r_f_prod, r_h_sq;
    logic r_h_pz;
    t_sq      sq_st [33];
    t_sq_side sq_sd [33];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_s    <= clamp_unit(rh_y[N]);
            r_e_c    <= clamp_unit(rm_x[N]);
            r_f_s    <= r_e_s;
            r_f_c    <= r_e_c;
            r_f_prod <= 64'(r_e_s[31:0]) * 64'(r_e_c[31:0]);
            if (r_f_s[32]) begin
                r_g_p <= r_f_c;
            end else if (r_f_c[32]) begin
                r_g_p <= r_f_s;
            end else begin
                r_g_p <= 33'((r_f_prod + ROUND_HALF) >> 32);
            end
            r_h_p  <= r_g_p;
            r_h_pz <= (r_g_p == '0);
            r_h_sq <= 64'(r_g_p[31:0]) * 64'(r_g_p[31:0]);
            sq_st[0].n <= r_h_p[32] ? '0 : 64'd0 - r_h_sq;
            sq_st[0].r <= '0;
            sq_sd[0].p  <= r_h_p;
            sq_sd[0].pz <= r_h_pz;
        end
    end

    for (genvar g = 0; g < 32; g++) begin : g_sqrt
        gtlo_sqrt_cell #(.K(g)) u_sq (
            .i_clk(i_clk), .i_en(en),
            .i_st(sq_st[g]), .i_sd(sq_sd[g]),
            .o_st(sq_st[g+1]), .o_sd(sq_sd[g+1])
        );
    end

    // vectoring chain: asin(p) = atan2(p, q)
    logic [32:0] q;
    t_cw v_x [N+1];
    t_cw v_y [N+1];
    t_cw v_z [N+1];

    assign q = sq_sd[32].pz ? ONE_Q32[32:0] : sq_st[32].r[32:0];
    assign v_x[0] = t_cw'({7'd0, q});
    assign v_y[0] = t_cw'({7'd0, sq_sd[32].p});
    assign v_z[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_vec
        gtlo_cordic_cell #(.IDX(g), .VECTOR(1'b1)) u_v (
            .i_clk(i_clk), .i_en(en),
            .i_x(v_x[g]), .i_y(v_y[g]), .i_z(v_z[g]),
            .o_x(v_x[g+1]), .o_y(v_y[g+1]), .o_z(v_z[g+1])
        );
    end

    // stages J, K: angle to millimetres
    logic [32:0] ang;
    logic [63:0] r_j_lo;
    logic [33:0] r_j_hi, r_j_ah;
    logic [35:0] ew_sum;
    logic [34:0] r_k_ew;

    assign ang = v_z[N][CW-1] ? '0 : v_z[N][32:0];
    assign ew_sum = 36'(r_j_ah) + 36'(r_j_hi) + 36'((r_j_lo + ROUND_HALF) >> 32);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_lo <= 64'(ang[31:0]) * 64'(TWO_R_MM[31:0]);
            r_j_hi <= 34'(ang[31:0]) * 34'(TWO_R_MM[33:32]);
            r_j_ah <= ang[32] ? TWO_R_MM[33:0] : '0;
            r_k_ew <= ew_sum[34:0];
        end
    end

    // valid line and output skid
    logic take;

    assign take     = r_o_v & o_ofs.ready;
    assign res.ew   = r_k_ew;
    assign res.ns   = r_dl[DLY-1].ns;
    assign res.down = r_dl[DLY-1].down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[LAT-2:0], acc};
            end
            if (en && r_v[LAT-1]) begin
                if (!r_o_v || take) begin
                    r_o_v <= 1'b1;
                end else begin
                    r_s_v <= 1'b1;
                end
            end else if (take) begin
                if (r_s_v) begin
                    r_s_v <= 1'b0;
                end else begin
                    r_o_v <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v[LAT-1]) begin
            if (!r_o_v || take) begin
                r_o <= res;
            end else begin
                r_s <= res;
            end
        end else if (take && r_s_v) begin
            r_o <= r_s;
        end
    end

    assign o_ofs.valid                = r_o_v;
    assign o_ofs.east_west_distance   = r_o.ew;
    assign o_ofs.north_south_distance = r_o.ns;
    assign o_ofs.down_offset          = r_o.down;

endmodule

/* rtl/core/gtlo_checker.sv */
// ----------------------------------------------------------------------------
// gtlo_checker
// Port-level checks of the offset block, bound to the top level.
// ----------------------------------------------------------------------------
module gtlo_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [34:0]       i_ew,
    input logic [34:0]       i_ns,
    input logic signed [27:0] i_down
);

    logic [15:0] r_cnt;
    logic in_beat, out_beat;

    assign in_beat  = i_in_valid & i_in_ready;
    assign out_beat = i_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 16'(in_beat) - 16'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("offset beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_ew) && $stable(i_ns) && $stable(i_down))
        else $error("offset payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("offset beat right after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("offset beat without an outstanding position beat");

endmodule

bind geodetic_to_local_offset gtlo_checker u_gtlo_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pos.valid),
    .i_in_ready (i_pos.ready),
    .i_out_valid(o_ofs.valid),
    .i_out_ready(o_ofs.ready),
    .i_ew       (o_ofs.east_west_distance),
    .i_ns       (o_ofs.north_south_distance),
    .i_down     (o_ofs.down_offset)
);
